[sv/lps_pkg.sv]
// Shared types and constants for the lap stopwatch.
// Used by lps_time and lap_stopwatch; depends on nothing.
`default_nettype none

package lps_pkg;

    // Command codes carried in func
    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_TOGGLE = 3'd1,
        FUNC_LAP    = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_READ   = 3'd4
    } func_t;

    // Codes reported on run_state
    typedef enum logic [1:0] {
        RUN_READY  = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_HELD   = 2'd2
    } run_state_t;

    // Configuration register indexes
    localparam logic CFG_LAP_LIMIT   = 1'b0;
    localparam logic CFG_SHOW_DELTAS = 1'b1;

    localparam int CFG_DATA_W  = 8;
    localparam int FUNC_W      = 3;
    localparam int INDEX_W     = 7;
    localparam int COUNT_W     = 8;
    localparam int TENTHS_W    = 4;
    localparam int SECONDS_W   = 6;

    // Digit wrap points
    localparam logic [TENTHS_W-1:0]  TENTHS_LAST  = 4'd9;
    localparam logic [SECONDS_W-1:0] SECONDS_LAST = 6'd59;
    localparam int TENTHS_PER_MINUTE = 600;

    // Reset values and parameter defaults
    localparam logic [CFG_DATA_W-1:0] LAP_LIMIT_RST   = 8'd20;
    localparam logic                  SHOW_DELTAS_RST = 1'b1;
    localparam int LAP_DEPTH_DEF = 128;
    localparam int TIME_BITS_DEF = 24;

    // Control from the command decoder to the time counter
    typedef struct packed {
        logic tick;
        logic clear;
    } time_ctl_t;

endpackage

`default_nettype wire

[sv/lps_lap_ram.sv]
// Lap duration store: one write port, one read port, registered read data.
// Depends on nothing outside this file.
`default_nettype none

module lps_lap_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Store a lap duration
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/lps_time.sv]
// Elapsed time counter with minute, second and tenth digits kept alongside.
// Depends on lps_pkg.
`default_nettype none

module lps_time
    import lps_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int MIN_BITS  = 15
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire time_ctl_t            ctl,
    output logic      [TIME_BITS-1:0] elapsed,
    output logic      [MIN_BITS-1:0]  minutes,
    output logic      [SECONDS_W-1:0] seconds,
    output logic      [TENTHS_W-1:0]  tenths,
    output logic                      at_max
);

    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [MIN_BITS-1:0]  min_reg, min_next;
    logic [SECONDS_W-1:0] sec_reg, sec_next;
    logic [TENTHS_W-1:0]  ten_reg, ten_next;

    // Advance the digits in step with the binary count
    always_comb
    begin
        elapsed_next = elapsed_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        ten_next     = ten_reg;
        if (ctl.clear)
        begin
            elapsed_next = '0;
            min_next     = '0;
            sec_next     = '0;
            ten_next     = '0;
        end
        else if (ctl.tick)
        begin
            elapsed_next = elapsed_reg + 1'b1;
            if (ten_reg == TENTHS_LAST)
            begin
                ten_next = '0;
                if (sec_reg == SECONDS_LAST)
                begin
                    sec_next = '0;
                    min_next = min_reg + 1'b1;
                end
                else
                begin
                    sec_next = sec_reg + 1'b1;
                end
            end
            else
            begin
                ten_next = ten_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            min_reg     <= '0;
            sec_reg     <= '0;
            ten_reg     <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            min_reg     <= min_next;
            sec_reg     <= sec_next;
            ten_reg     <= ten_next;
        end
    end

    assign elapsed = elapsed_reg;
    assign minutes = min_reg;
    assign seconds = sec_reg;
    assign tenths  = ten_reg;
    assign at_max  = &elapsed_reg;

`ifndef SYNTH
    a_tenths_range: assert property (@(posedge clk) disable iff (!rst_n)
        ten_reg <= TENTHS_LAST)
        else $error("tenths digit out of range");

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg <= SECONDS_LAST)
        else $error("seconds digit out of range");

    a_tick_digit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.tick && !ctl.clear |=> (ten_reg == '0) == ($past(ten_reg) == TENTHS_LAST))
        else $error("tenths digit did not follow the tick");
`endif

endmodule

`default_nettype wire

[sv/lap_stopwatch.sv]
// Lap stopwatch top level: command decode, lap bookkeeping and result register.
// Depends on lps_pkg, lps_time and lps_lap_ram.
`default_nettype none

// One command is taken per clock while the result register is free or
// draining, so a new command may follow every cycle; each command gives
// exactly one result beat in the cycle after it is taken. A read lap command
// reads the lap memory at its own acceptance edge and the stored duration
// appears with that result. The time digits are kept as counters that
// follow the tick, so no divider sits in the output path. The lap store is
// not cleared after reset; only entries below laps_recorded are reported.
module lap_stopwatch
    import lps_pkg::*;
#(
    parameter int LAP_DEPTH = LAP_DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam longint TIME_MAX_L = (64'd1 << TIME_BITS) - 64'd1,
    localparam int MIN_BITS  = $clog2(TIME_MAX_L / TENTHS_PER_MINUTE + 1),
    localparam int ADDR_W    = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [FUNC_W-1:0]      func,
    input  wire logic [INDEX_W-1:0]     lap_index,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [1:0]             run_state,
    output logic      [TIME_BITS-1:0]   elapsed_tenths,
    output logic      [MIN_BITS-1:0]    minutes,
    output logic      [SECONDS_W-1:0]   seconds,
    output logic      [TENTHS_W-1:0]    tenths_digit,
    output logic      [COUNT_W-1:0]     laps_recorded,
    output logic signed [TIME_BITS:0]   lap_delta,
    output logic                        delta_visible,
    output logic      [TIME_BITS-1:0]   lap_value,
    output logic                        lap_value_valid,
    output logic                        accepted,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [CFG_DATA_W-1:0] lap_limit_reg;
    logic                  show_deltas_reg;

    logic                  running_reg, running_next;
    logic [COUNT_W-1:0]    lap_cnt_reg, lap_cnt_next;
    logic [TIME_BITS-1:0]  lap_start_reg, lap_start_next;
    logic [TIME_BITS:0]    delta_reg, delta_next;
    logic [TIME_BITS-1:0]  prev_dur_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  accepted_reg, accepted_next;
    logic                  lap_valid_reg, lap_valid_next;

    logic                  take;
    logic                  lap_take;
    logic                  read_en;
    logic [TIME_BITS-1:0]  lap_dur;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  at_max;
    logic [TIME_BITS-1:0]  rd_data;
    time_ctl_t             time_ctl;

    // Take a beat whenever the result register is empty or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    assign lap_dur = elapsed - lap_start_reg;

    // Decode one command
    always_comb
    begin
        running_next   = running_reg;
        lap_cnt_next   = lap_cnt_reg;
        lap_start_next = lap_start_reg;
        delta_next     = delta_reg;
        accepted_next  = 1'b0;
        lap_valid_next = 1'b0;
        time_ctl       = '0;
        lap_take       = 1'b0;
        read_en        = 1'b0;
        if (take)
        begin
            unique case (func)
                FUNC_TICK:
                begin
                    if (running_reg && !at_max)
                    begin
                        time_ctl.tick = 1'b1;
                        accepted_next = 1'b1;
                    end
                end
                FUNC_TOGGLE:
                begin
                    running_next  = !running_reg;
                    accepted_next = 1'b1;
                end
                FUNC_LAP:
                begin
                    if (running_reg && (lap_cnt_reg < lap_limit_reg)
                        && (32'(lap_cnt_reg) < LAP_DEPTH))
                    begin
                        lap_take       = 1'b1;
                        lap_cnt_next   = lap_cnt_reg + 1'b1;
                        lap_start_next = elapsed;
                        accepted_next  = 1'b1;
                        if (lap_cnt_reg != '0)
                        begin
                            delta_next = {1'b0, lap_dur} - {1'b0, prev_dur_reg};
                        end
                        else
                        begin
                            delta_next = '0;
                        end
                    end
                end
                FUNC_CLEAR:
                begin
                    if (!running_reg)
                    begin
                        time_ctl.clear = 1'b1;
                        lap_cnt_next   = '0;
                        lap_start_next = '0;
                        delta_next     = '0;
                        accepted_next  = 1'b1;
                    end
                end
                FUNC_READ:
                begin
                    if ((COUNT_W'(lap_index) < lap_cnt_reg) && (32'(lap_index) < LAP_DEPTH))
                    begin
                        read_en        = 1'b1;
                        lap_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    accepted_next = 1'b0;
                end
            endcase
        end
    end

    // Result register: fill on a taken beat, empty when drained
    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lap_limit_reg   <= LAP_LIMIT_RST;
            show_deltas_reg <= SHOW_DELTAS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LAP_LIMIT:   lap_limit_reg   <= cfg_wdata;
                CFG_SHOW_DELTAS: show_deltas_reg <= cfg_wdata[0];
                default:         lap_limit_reg   <= lap_limit_reg;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            lap_cnt_reg   <= '0;
            lap_start_reg <= '0;
            delta_reg     <= '0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            lap_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            lap_cnt_reg   <= lap_cnt_next;
            lap_start_reg <= lap_start_next;
            delta_reg     <= delta_next;
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                accepted_reg  <= accepted_next;
                lap_valid_reg <= lap_valid_next;
            end
        end
    end

    // Keep a copy of the newest stored lap for the delta
    always_ff @(posedge clk)
    begin
        if (lap_take)
        begin
            prev_dur_reg <= lap_dur;
        end
    end

    lps_time #(
        .TIME_BITS (TIME_BITS),
        .MIN_BITS  (MIN_BITS)
    ) u_time (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (time_ctl),
        .elapsed (elapsed),
        .minutes (minutes),
        .seconds (seconds),
        .tenths  (tenths_digit),
        .at_max  (at_max)
    );

    lps_lap_ram #(
        .DEPTH  (LAP_DEPTH),
        .WIDTH  (TIME_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (lap_take),
        .waddr (ADDR_W'(lap_cnt_reg)),
        .wdata (lap_dur),
        .re    (read_en),
        .raddr (ADDR_W'(lap_index)),
        .rdata (rd_data)
    );

    // Drive the result beat from the settled state
    always_comb
    begin
        if (running_reg)
        begin
            run_state = RUN_ACTIVE;
        end
        else if (elapsed != '0)
        begin
            run_state = RUN_HELD;
        end
        else
        begin
            run_state = RUN_READY;
        end
    end

    assign out_valid       = out_valid_reg;
    assign elapsed_tenths  = elapsed;
    assign laps_recorded   = lap_cnt_reg;
    assign lap_delta       = delta_reg;
    assign delta_visible   = show_deltas_reg && (lap_cnt_reg > COUNT_W'(1)) && (delta_reg != '0);
    assign lap_value       = lap_valid_reg ? rd_data : '0;
    assign lap_value_valid = lap_valid_reg;
    assign accepted        = accepted_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(lap_cnt_reg) <= LAP_DEPTH)
        else $error("lap count beyond store depth");

    a_lap_advance: assert property (@(posedge clk) disable iff (!rst_n)
        lap_take |=> lap_cnt_reg == $past(lap_cnt_reg) + 1'b1)
        else $error("lap count did not advance on a stored lap");

    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && lap_valid_reg |-> !accepted_reg)
        else $error("read lap reported as a state change");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(lap_cnt_reg) && $stable(running_reg))
        else $error("state moved while the result beat was held");
`endif

endmodule

`default_nettype wire
